// ===== design/ntcc_pkg.sv =====
// Shared types, codes and defaults of the neighbour table and cooling controller.
package ntcc_pkg;

  // Default sizes and register reset values.
  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned AddrW         = 16;
  localparam int unsigned TimerW        = 16;

  localparam logic [15:0] AgingTicksRst    = 16'd90;
  localparam logic [7:0]  TempThresholdRst = 8'd70;
  localparam logic [7:0]  OffReadingsRst   = 8'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_AGING_TICKS    = 2'd0;
  localparam logic [1:0] CFG_TEMP_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_OFF_READINGS   = 2'd2;

  // Input codes.
  localparam logic [1:0] MODE_BCAST = 2'd0;
  localparam logic [1:0] MODE_UCAST = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] AC_REMOTE_OFF = 2'd0;
  localparam logic [1:0] AC_REMOTE_ON  = 2'd1;
  localparam logic [1:0] AC_BEACON     = 2'd2;

  localparam logic MSG_PING = 1'b0;

  // Result kinds.
  localparam logic [2:0] KIND_REFRESHED = 3'd0;
  localparam logic [2:0] KIND_ADDED     = 3'd1;
  localparam logic [2:0] KIND_DROPPED   = 3'd2;
  localparam logic [2:0] KIND_REMOTE    = 3'd3;
  localparam logic [2:0] KIND_PONG      = 3'd4;
  localparam logic [2:0] KIND_ANNOUNCE  = 3'd5;
  localparam logic [2:0] KIND_EXPIRED   = 3'd6;
  localparam logic [2:0] KIND_NONE      = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] src_addr;
    logic [1:0]  ac_code;
    logic        msg_type;
    logic [7:0]  temperature;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  echo_temp;
    logic        cooling_on;
    logic        remote_on;
    logic        green_led;
    logic        red_led;
    logic [4:0]  neighbor_count;
    logic        last;
  } out_item_t;

  // One table entry as held in the entry RAM.
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [TimerW-1:0] timer;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEACON,
    ST_BWRITE,
    ST_REMOTE,
    ST_PING,
    ST_HYST,
    ST_AGE,
    ST_DONE
  } ntcc_state_e;

endpackage

// ===== design/neighbor_table_cooling_controller_unit.sv =====
// Top level: neighbour table with aging and cooling hysteresis, one sequencer over the table RAM.
//
//   channel   direction  handshake                        payload
//   command   in         start high while busy low        in_item_i   (in_item_t)
//   result    out        res_strobe_o, one cycle a beat   res_o       (out_item_t)
//   config    in         cfg_valid_i and cfg_ready_o      cfg_index_i, cfg_data_i
//
// A beacon or a tick scans the table, one entry a cycle through the RAM read port.
// Results trail the sequencer by one held beat, so the final one appears in the cycle
// in which busy falls. Reset clears the valid bits, counters and flags; the RAM needs none.
// The receiver cannot stall, so the block never waits on the result side.
module neighbor_table_cooling_controller_unit
  import ntcc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item_i,
  output logic        res_strobe_o,
  output out_item_t   res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  ntcc_state_e state_q, state_d;
  in_item_t    item_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q, hit_d, free_q, free_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0] count_q, count_d;
  logic cool_q, cool_d, remote_q, remote_d, green_q, green_d, red_q, red_d;
  logic [7:0] low_cnt_q, low_cnt_d, low_cnt_inc;

  logic [15:0] aging_q;
  logic [7:0]  thresh_q, off_q;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, rd_entry;

  logic        emit, flush;
  logic [2:0]  emit_kind;
  logic [15:0] emit_addr;
  logic [7:0]  emit_temp;
  out_item_t   emit_item;
  logic [CntW+4:0] count_ext;

  out_item_t pend_q;
  logic      pend_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t flush_item;

  logic accept, cfg_write, last_idx, entry_valid;

  assign accept      = start && !busy;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign last_idx    = (idx_q == LastIdx);
  assign entry_valid = valid_q[idx_q];
  assign low_cnt_inc = (low_cnt_q == 8'hFF) ? low_cnt_q : low_cnt_q + 8'd1;

  // The read port runs one entry ahead of the entry being examined.
  always_comb begin
    if (state_q == ST_IDLE || last_idx) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = idx_q + IdxW'(1);
    end
  end

  ntcc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
      cool_q    <= 1'b0;
      remote_q  <= 1'b0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      low_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      cool_q    <= cool_d;
      remote_q  <= remote_d;
      green_q   <= green_d;
      red_q     <= red_d;
      low_cnt_q <= low_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_q  <= AgingTicksRst;
      thresh_q <= TempThresholdRst;
      off_q    <= OffReadingsRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_AGING_TICKS:    aging_q  <= cfg_data_i;
        CFG_TEMP_THRESHOLD: thresh_q <= cfg_data_i[7:0];
        CFG_OFF_READINGS:   off_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    count_d    = count_q;
    cool_d     = cool_q;
    remote_d   = remote_q;
    green_d    = green_q;
    red_d      = red_q;
    low_cnt_d  = low_cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = rd_entry;
    emit       = 1'b0;
    emit_kind  = KIND_NONE;
    emit_addr  = '0;
    emit_temp  = '0;
    flush      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        idx_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        if (accept) begin
          case (in_item_i.mode)
            MODE_BCAST: begin
              if (in_item_i.ac_code == AC_BEACON) begin
                state_d = ST_BEACON;
              end else if (in_item_i.ac_code == AC_REMOTE_ON ||
                           in_item_i.ac_code == AC_REMOTE_OFF) begin
                state_d = ST_REMOTE;
              end else begin
                state_d = ST_DONE;
              end
            end
            MODE_UCAST: begin
              state_d = (in_item_i.msg_type == MSG_PING) ? ST_PING : ST_DONE;
            end
            MODE_TICK: state_d = ST_AGE;
            default:   state_d = ST_DONE;
          endcase
        end
      end

      ST_BEACON: begin
        if (entry_valid && rd_entry.addr == item_q.src_addr && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
        end
        if (!entry_valid && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (last_idx) begin
          state_d = ST_BWRITE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_BWRITE: begin
        emit      = 1'b1;
        emit_addr = item_q.src_addr;
        ram_wdata = '{addr: item_q.src_addr, timer: aging_q};
        if (hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          emit_kind = KIND_REFRESHED;
        end else if (free_q) begin
          ram_we              = 1'b1;
          ram_waddr           = free_idx_q;
          valid_d[free_idx_q] = 1'b1;
          count_d             = count_q + CntW'(1);
          emit_kind           = KIND_ADDED;
        end else begin
          emit_kind = KIND_DROPPED;
        end
        state_d = ST_DONE;
      end

      ST_REMOTE: begin
        remote_d  = (item_q.ac_code == AC_REMOTE_ON);
        green_d   = (item_q.ac_code == AC_REMOTE_ON);
        emit      = 1'b1;
        emit_kind = KIND_REMOTE;
        state_d   = ST_DONE;
      end

      // The pong carries the cooling state from before the hysteresis step.
      ST_PING: begin
        emit      = 1'b1;
        emit_kind = KIND_PONG;
        emit_addr = item_q.src_addr;
        emit_temp = item_q.temperature;
        state_d   = ST_HYST;
      end

      ST_HYST: begin
        if (item_q.temperature > thresh_q) begin
          low_cnt_d = '0;
          if (!cool_q && !remote_q) begin
            cool_d    = 1'b1;
            green_d   = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_ANNOUNCE;
          end
        end else begin
          low_cnt_d = low_cnt_inc;
          if (cool_q && low_cnt_inc == off_q) begin
            cool_d    = 1'b0;
            green_d   = 1'b0;
            low_cnt_d = '0;
            emit      = 1'b1;
            emit_kind = KIND_ANNOUNCE;
          end
        end
        state_d = ST_DONE;
      end

      ST_AGE: begin
        if (entry_valid) begin
          if (rd_entry.timer <= TimerW'(1)) begin
            valid_d[idx_q] = 1'b0;
            count_d        = count_q - CntW'(1);
            red_d          = 1'b1;
            emit           = 1'b1;
            emit_kind      = KIND_EXPIRED;
            emit_addr      = rd_entry.addr;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{addr: rd_entry.addr, timer: rd_entry.timer - TimerW'(1)};
          end
        end
        if (last_idx) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_DONE: begin
        flush   = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Each result carries the state as it stands once that result has taken effect.
  assign count_ext = {5'd0, count_d};

  always_comb begin
    emit_item.kind           = emit_kind;
    emit_item.addr           = emit_addr;
    emit_item.echo_temp      = emit_temp;
    emit_item.cooling_on     = cool_d;
    emit_item.remote_on      = remote_d;
    emit_item.green_led      = green_d;
    emit_item.red_led        = red_d;
    emit_item.neighbor_count = count_ext[4:0];
    emit_item.last           = 1'b0;
  end

  always_comb begin
    flush_item      = pend_valid_q ? pend_q : emit_item;
    flush_item.last = 1'b1;
  end

  // One result is held back until the next one, or the end of the item, shows
  // whether it is the final beat. With nothing held, the end gives a none beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit) begin
        pend_valid_q <= 1'b1;
        out_valid_q  <= pend_valid_q;
      end else if (flush) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_q <= emit_item;
      out_q  <= pend_q;
    end else if (flush) begin
      out_q <= flush_item;
    end
  end

  assign res_strobe_o = out_valid_q;
  assign res_o        = out_q;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("neighbour count disagrees with the valid bits");

  a_last_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> $past(state_q == ST_DONE))
    else $error("final beat appeared outside the end of an item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_no_held_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != ST_IDLE))
    else $error("held result left behind after the item ended");

  a_red_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(red_q))
    else $error("red LED cleared without reset");
`endif

endmodule

// ===== design/ntcc_ram.sv =====
// Generic RAM with one write port and one registered read port.
module ntcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_neighbor_table_cooling_controller_unit.sv =====
// Self-checking testbench for the neighbour table and cooling controller unit.
module tb_neighbor_table_cooling_controller_unit;
  import ntcc_pkg::*;

  localparam int unsigned Depth      = DefTableDepth;
  localparam int unsigned SettleCyc  = 2 * (Depth + 3) + 4;
  localparam int unsigned CycLimit   = 600000;
  localparam int unsigned PoolSize   = 20;
  localparam int unsigned PhaseItems = 38;

  // Codes the package leaves unnamed because the block ignores them.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] AC_IGNORE  = 2'd3;
  localparam logic       MSG_PONG   = 1'b1;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    cmd_d     = '0;
  logic        res_strobe;
  out_item_t   res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Own copy of the node state and its registers.
  bit          nb_valid [Depth];
  logic [15:0] nb_addr  [Depth];
  logic [15:0] nb_timer [Depth];
  bit          cooling, remote, green, red;
  int unsigned low_run;
  logic [15:0] aging_cfg;
  logic [7:0]  thresh_cfg;
  logic [7:0]  off_cfg;

  out_item_t   due_beats[$];
  script_row_t script[$];
  logic [15:0] addr_pool [PoolSize];
  int unsigned bad_beats;
  int unsigned shown;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left;

  neighbor_table_cooling_controller_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item_i    (cmd_d),
    .res_strobe_o (res_strobe),
    .res_o        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_item_t mk_cmd(logic [1:0] mode, logic [15:0] src, logic [1:0] ac,
                                      logic mt, logic [7:0] temp);
    in_item_t c;
    c.mode        = mode;
    c.src_addr    = src;
    c.ac_code     = ac;
    c.msg_type    = mt;
    c.temperature = temp;
    return c;
  endfunction

  function automatic out_item_t mk_beat(logic [2:0] kind, logic [15:0] addr, logic [7:0] temp,
                                        logic cool, logic rem, logic grn, logic rd,
                                        logic [4:0] cnt, logic fin);
    out_item_t b;
    b.kind           = kind;
    b.addr           = addr;
    b.echo_temp      = temp;
    b.cooling_on     = cool;
    b.remote_on      = rem;
    b.green_led      = grn;
    b.red_led        = rd;
    b.neighbor_count = cnt;
    b.last           = fin;
    return b;
  endfunction

  function automatic logic [4:0] table_fill();
    int n;
    n = 0;
    for (int i = 0; i < Depth; i++) n += nb_valid[i];
    return 5'(n);
  endfunction

  function automatic out_item_t now_beat(logic [2:0] kind, logic [15:0] addr, logic [7:0] temp);
    return mk_beat(kind, addr, temp, cooling, remote, green, red, table_fill(), 1'b0);
  endfunction

  // Advances the node state by one command; the beats are queued only when keep is set.
  function automatic void apply_cmd(in_item_t c, bit keep);
    out_item_t beats[$];
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    case (c.mode)
      MODE_BCAST: begin
        if (c.ac_code == AC_BEACON) begin
          for (int i = 0; i < Depth; i++) begin
            if (nb_valid[i] && nb_addr[i] == c.src_addr && hit < 0) hit = i;
            if (!nb_valid[i] && slot < 0) slot = i;
          end
          if (hit >= 0) begin
            nb_timer[hit] = aging_cfg;
            beats.push_back(now_beat(KIND_REFRESHED, c.src_addr, 8'h00));
          end else if (slot >= 0) begin
            nb_valid[slot] = 1'b1;
            nb_addr[slot]  = c.src_addr;
            nb_timer[slot] = aging_cfg;
            beats.push_back(now_beat(KIND_ADDED, c.src_addr, 8'h00));
          end else begin
            beats.push_back(now_beat(KIND_DROPPED, c.src_addr, 8'h00));
          end
        end else if (c.ac_code != AC_IGNORE) begin
          remote = (c.ac_code == AC_REMOTE_ON);
          green  = remote;
          beats.push_back(now_beat(KIND_REMOTE, 16'h0000, 8'h00));
        end
      end
      MODE_UCAST: begin
        if (c.msg_type == MSG_PING) begin
          // The pong reports the cooling state from before the hysteresis step.
          beats.push_back(now_beat(KIND_PONG, c.src_addr, c.temperature));
          if (c.temperature > thresh_cfg) begin
            low_run = 0;
            if (!cooling && !remote) begin
              cooling = 1'b1;
              green   = 1'b1;
              beats.push_back(now_beat(KIND_ANNOUNCE, 16'h0000, 8'h00));
            end
          end else begin
            if (low_run < 255) low_run++;
            if (cooling && low_run == off_cfg) begin
              green   = 1'b0;
              low_run = 0;
              cooling = 1'b0;
              beats.push_back(now_beat(KIND_ANNOUNCE, 16'h0000, 8'h00));
            end
          end
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < Depth; i++) begin
          if (nb_valid[i]) begin
            if (nb_timer[i] <= 16'd1) begin
              nb_timer[i] = 16'd0;
              nb_valid[i] = 1'b0;
              red         = 1'b1;
              beats.push_back(now_beat(KIND_EXPIRED, nb_addr[i], 8'h00));
            end else begin
              nb_timer[i]--;
            end
          end
        end
      end
      default: ;
    endcase
    if (beats.size() == 0) beats.push_back(now_beat(KIND_NONE, 16'h0000, 8'h00));
    beats[beats.size() - 1].last = 1'b1;
    if (keep) foreach (beats[i]) due_beats.push_back(beats[i]);
  endfunction

  function automatic string beat_str(out_item_t b);
    return $sformatf("kind %0d addr %h temp %h cool %b rem %b grn %b red %b cnt %0d last %b",
                     b.kind, b.addr, b.echo_temp, b.cooling_on, b.remote_on, b.green_led,
                     b.red_led, b.neighbor_count, b.last);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && res_strobe) begin
      if (due_beats.size() == 0) begin
        bad_beats++;
        if (shown < 10) begin
          shown++;
          $display("%0t: beat with nothing expected: %s", $time, beat_str(res));
        end
      end else begin
        want = due_beats.pop_front();
        if (res.kind !== want.kind || res.addr !== want.addr ||
            res.echo_temp !== want.echo_temp || res.cooling_on !== want.cooling_on ||
            res.remote_on !== want.remote_on || res.green_led !== want.green_led ||
            res.red_led !== want.red_led || res.neighbor_count !== want.neighbor_count ||
            res.last !== want.last) begin
          bad_beats++;
          if (shown < 10) begin
            shown++;
            $display("%0t: beat mismatch", $time);
            $display("  expected %s", beat_str(want));
            $display("  actual   %s", beat_str(res));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The sender works in bursts; between bursts start drops for a random pause.
  function automatic int unsigned next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
  endfunction

  task automatic send_cmd(in_item_t c, bit typed, out_item_t want);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd_d <= c;
    do @(posedge clk); while (busy);
    apply_cmd(c, !typed);
    if (typed) due_beats.push_back(want);
  endtask

  task automatic settle();
    @(negedge clk) start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AGING_TICKS:    aging_cfg  = data;
      CFG_TEMP_THRESHOLD: thresh_cfg = data[7:0];
      CFG_OFF_READINGS:   off_cfg    = data[7:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // The upper byte of the 8-bit registers carries junk that the block must drop.
  task automatic configure(logic [15:0] aging, logic [7:0] thresh, logic [7:0] off,
                           logic [7:0] junk);
    settle();
    write_reg(CFG_AGING_TICKS, aging);
    write_reg(CFG_TEMP_THRESHOLD, {junk, thresh});
    write_reg(CFG_OFF_READINGS, {junk, off});
  endtask

  task automatic add_row(in_item_t c, bit typed, out_item_t want);
    script_row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  function automatic in_item_t rand_cmd();
    in_item_t    c;
    logic [31:0] r;
    int          t;
    int unsigned pick;
    r    = $urandom;
    c    = r[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      c.mode    = MODE_BCAST;
      c.ac_code = AC_BEACON;
      if ($urandom_range(0, 6) != 0) c.src_addr = addr_pool[$urandom_range(0, PoolSize - 1)];
    end else if (pick < 60) begin
      c.mode = MODE_TICK;
    end else if (pick < 86) begin
      c.mode     = MODE_UCAST;
      c.msg_type = MSG_PING;
      // Half the readings sit near the threshold, from one below to two above it.
      if ($urandom_range(0, 1) == 1) begin
        t = int'(thresh_cfg) + int'($urandom_range(0, 3)) - 1;
        c.temperature = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
      end
    end else if (pick < 94) begin
      c.mode    = MODE_BCAST;
      c.ac_code = ($urandom_range(0, 1) == 1) ? AC_REMOTE_ON : AC_REMOTE_OFF;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          c.mode    = MODE_BCAST;
          c.ac_code = AC_IGNORE;
        end
        1: begin
          c.mode     = MODE_UCAST;
          c.msg_type = MSG_PONG;
        end
        default: c.mode = MODE_SPARE;
      endcase
    end
    return c;
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned sent;
    int unsigned base;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 24) == 0) begin
        // Beacons from more sources than the table holds, then a tick to age them all.
        base = $urandom_range(0, PoolSize - 1);
        for (int k = 0; k <= Depth; k++) begin
          send_cmd(mk_cmd(MODE_BCAST, addr_pool[(base + k) % PoolSize], AC_BEACON,
                          1'($urandom), 8'($urandom)), 1'b0, '0);
        end
        send_cmd(mk_cmd(MODE_TICK, 16'($urandom), 2'($urandom), 1'($urandom),
                        8'($urandom)), 1'b0, '0);
        sent += Depth + 2;
      end else begin
        send_cmd(rand_cmd(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    out_item_t quiet;
    for (int i = 0; i < Depth; i++) begin
      nb_valid[i] = 1'b0;
      nb_addr[i]  = 16'h0000;
      nb_timer[i] = 16'h0000;
    end
    cooling    = 1'b0;
    remote     = 1'b0;
    green      = 1'b0;
    red        = 1'b0;
    low_run    = 0;
    aging_cfg  = AgingTicksRst;
    thresh_cfg = TempThresholdRst;
    off_cfg    = OffReadingsRst;
    burst_left = 0;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = 16'($urandom);

    quiet = mk_beat(KIND_NONE, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b1);
    add_row(mk_cmd(MODE_TICK, 16'h0000, 2'd0, 1'b0, 8'h00), 1'b1, quiet);
    add_row(mk_cmd(MODE_SPARE, 16'hFFFF, AC_IGNORE, MSG_PONG, 8'hFF), 1'b1, quiet);
    add_row(mk_cmd(MODE_BCAST, 16'hFFFF, AC_IGNORE, MSG_PING, 8'h00), 1'b1, quiet);
    add_row(mk_cmd(MODE_UCAST, 16'hFFFF, AC_IGNORE, MSG_PONG, 8'hFF), 1'b1, quiet);
    add_row(mk_cmd(MODE_BCAST, 16'h0000, AC_REMOTE_ON, MSG_PING, 8'h00), 1'b1,
            mk_beat(KIND_REMOTE, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 1'b1));
    // A hot reading is ignored while the remote flag holds.
    add_row(mk_cmd(MODE_UCAST, 16'hFFFF, AC_BEACON, MSG_PING, 8'hFF), 1'b1,
            mk_beat(KIND_PONG, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 1'b1));
    add_row(mk_cmd(MODE_BCAST, 16'hFFFF, AC_REMOTE_OFF, MSG_PONG, 8'hFF), 1'b1,
            mk_beat(KIND_REMOTE, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 1'b1));
    add_row(mk_cmd(MODE_UCAST, 16'h1234, 2'd0, MSG_PING, 8'd71), 1'b0, '0);
    add_row(mk_cmd(MODE_UCAST, 16'h4321, 2'd0, MSG_PING, 8'd70), 1'b0, '0);
    add_row(mk_cmd(MODE_UCAST, 16'h0001, 2'd0, MSG_PING, 8'd0), 1'b0, '0);
    add_row(mk_cmd(MODE_UCAST, 16'h8000, 2'd0, MSG_PING, 8'd0), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'h0000, AC_BEACON, MSG_PING, 8'h00), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'hFFFF, AC_BEACON, MSG_PING, 8'hFF), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'h0000, AC_BEACON, MSG_PONG, 8'h00), 1'b0, '0);
    add_row(mk_cmd(MODE_UCAST, 16'h00FF, 2'd0, MSG_PING, 8'd255), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'hA5A5, AC_BEACON, MSG_PONG, 8'h5A), 1'b0, '0);
    add_row(mk_cmd(MODE_TICK, 16'hFFFF, AC_IGNORE, MSG_PONG, 8'hFF), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'h5A5A, AC_REMOTE_ON, MSG_PING, 8'h00), 1'b0, '0);
    add_row(mk_cmd(MODE_UCAST, 16'h7FFF, AC_REMOTE_ON, MSG_PING, 8'd3), 1'b0, '0);
    add_row(mk_cmd(MODE_BCAST, 16'h0F0F, AC_REMOTE_OFF, MSG_PING, 8'h00), 1'b0, '0);
    add_row(mk_cmd(MODE_TICK, 16'h0000, AC_BEACON, MSG_PING, 8'h00), 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (script[i]) send_cmd(script[i].cmd, script[i].typed, script[i].want);
    random_phase(PhaseItems);
    configure(16'd1, 8'd0, 8'd1, 8'h00);
    random_phase(PhaseItems);
    // Zero ageing expires on the next tick; a zero off count never switches off.
    configure(16'd0, 8'd128, 8'd0, 8'h00);
    random_phase(PhaseItems);
    configure(16'($urandom_range(2, 6)), 8'($urandom), 8'($urandom_range(1, 4)), 8'h5A);
    random_phase(PhaseItems);
    configure(16'($urandom_range(3, 12)), 8'($urandom_range(40, 90)),
              8'($urandom_range(2, 6)), 8'hFF);
    random_phase(PhaseItems);
    configure(16'd65535, 8'd255, 8'd255, 8'hA5);
    random_phase(PhaseItems);
    settle();

    if (bad_beats == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
